### hw/rtl/uba_pkg.sv
// ----------------------------------------------------------------------------
// Unit bitmap allocator package
// Shared widths, register addresses and the token that travels along the
// row of allocator cells.
// ----------------------------------------------------------------------------
package uba_pkg;

  localparam int unsigned MAP_W        = 64;
  localparam int unsigned CNT_W        = 7;
  localparam int unsigned DATA_W       = 32;
  localparam int unsigned ADDR_W       = 3;
  localparam int unsigned MAX_UNITS_DF = 64;
  localparam int unsigned TOTAL_RST    = 64;

  localparam logic REG_TOTAL_UNITS = 1'b0;

  localparam logic CMD_ALLOC   = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  typedef struct packed {
    logic             vld;
    logic             alloc;
    logic [CNT_W-1:0] left;
    logic [CNT_W-1:0] cnt;
  } token_t;

  typedef struct packed {
    logic start;
    logic rel;
    logic commit;
  } cell_ctrl_t;

endpackage

### hw/rtl/unit_bitmap_allocator_top.sv
// ----------------------------------------------------------------------------
// Unit bitmap allocator
// Lowest-free-first allocator over a row of unit cells.
// ----------------------------------------------------------------------------
// A transaction is issued by raising start while busy is low. An allocate
// grants the request_count lowest-numbered free units below total_units, or
// nothing with status set when too few are free. A release clears the
// units in release_map. Each transaction gives one result, shown for one
// cycle with done_o high: grant_map, status, busy_map and busy_count.
// A token walks the row of MAX_UNITS cells, one cell per cycle. The result
// is registered from the token that leaves the last cell and is taken by the
// receiver in the cycle in which done_o is high. Busy falls in that same
// cycle, so the next transaction can be accepted at the edge that ends it;
// a new transaction is not accepted while one is still in the row.
// The result cannot be stalled by the receiver. Reset frees all units,
// clears busy_total_q and sets total_units to 64. total_units is written
// through the APB port at address 0 and must only change while idle.
// ----------------------------------------------------------------------------
module unit_bitmap_allocator_top #(
  parameter int unsigned MAX_UNITS = uba_pkg::MAX_UNITS_DF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [uba_pkg::ADDR_W-1:0]  paddr,
  input  logic [uba_pkg::DATA_W-1:0]  pwdata,
  output logic [uba_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  input  logic                        start,
  output logic                        busy,
  input  logic                        cmd_i,
  input  logic [uba_pkg::CNT_W-1:0]   request_count_i,
  input  logic [uba_pkg::MAP_W-1:0]   release_map_i,
  output logic                        done_o,
  output logic [uba_pkg::MAP_W-1:0]   grant_map_o,
  output logic                        status_o,
  output logic [uba_pkg::MAP_W-1:0]   busy_map_o,
  output logic [uba_pkg::CNT_W-1:0]   busy_count_o
);
  import uba_pkg::*;

  logic [CNT_W-1:0] total_q, total_d, total_sat;
  logic             active_q, active_d;
  token_t           tok0_q, tok0_d;
  logic             rel_q, rel_d;
  logic [CNT_W-1:0] busy_total_q, busy_total_d;
  logic             done_q, done_d;
  logic [MAP_W-1:0] grant_q, grant_d, map_q, map_d;
  logic             status_q, status_d;
  logic [CNT_W-1:0] count_q, count_d;

  token_t           tok [MAX_UNITS+1];
  logic [MAX_UNITS-1:0] busy_vec, grant_vec, present_vec;
  cell_ctrl_t       ctrl;
  logic             accept, finish, fail, success;
  logic             cfg_wr;

  assign accept  = start & ~active_q;
  assign finish  = tok[MAX_UNITS].vld;
  assign fail    = tok[MAX_UNITS].alloc & (tok[MAX_UNITS].left != '0);
  assign success = finish & tok[MAX_UNITS].alloc & ~fail;

  assign ctrl.start  = accept;
  assign ctrl.rel    = (cmd_i == CMD_RELEASE);
  assign ctrl.commit = success;

  assign cfg_wr = psel & penable & pwrite & pready;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_TOTAL_UNITS) ? DATA_W'(total_q) : '0;

  assign total_sat = (total_q > CNT_W'(MAX_UNITS)) ? CNT_W'(MAX_UNITS) : total_q;

  assign tok[0] = tok0_q;

  for (genvar i = 0; i < MAX_UNITS; i++) begin : g_cell
    assign present_vec[i] = CNT_W'(i) < total_sat;
    uba_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .release_i (release_map_i[i]),
      .present_i (present_vec[i]),
      .tok_i     (tok[i]),
      .tok_o     (tok[i+1]),
      .busy_o    (busy_vec[i]),
      .grant_o   (grant_vec[i])
    );
  end

  always_comb begin
    total_d = total_q;
    if (cfg_wr && paddr[2] == REG_TOTAL_UNITS) begin
      total_d = pwdata[CNT_W-1:0];
    end
  end

  always_comb begin
    active_d     = active_q;
    tok0_d       = '0;
    rel_d        = rel_q;
    busy_total_d = busy_total_q;
    if (accept) begin
      active_d     = 1'b1;
      rel_d        = (cmd_i == CMD_RELEASE);
      tok0_d.vld   = 1'b1;
      tok0_d.alloc = (cmd_i == CMD_ALLOC);
      tok0_d.left  = (cmd_i == CMD_ALLOC) ? request_count_i : '0;
      tok0_d.cnt   = '0;
    end else if (finish) begin
      active_d     = 1'b0;
      busy_total_d = count_d;
    end
  end

  always_comb begin
    done_d   = finish;
    grant_d  = grant_q;
    status_d = status_q;
    map_d    = map_q;
    count_d  = count_q;
    if (finish) begin
      grant_d  = success ? MAP_W'(grant_vec) : '0;
      status_d = fail;
      map_d    = MAP_W'(busy_vec | (success ? grant_vec : '0));
      count_d  = fail ? busy_total_q : tok[MAX_UNITS].cnt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q      <= CNT_W'(TOTAL_RST);
      active_q     <= 1'b0;
      tok0_q       <= '0;
      rel_q        <= 1'b0;
      busy_total_q <= '0;
      done_q       <= 1'b0;
    end else begin
      total_q      <= total_d;
      active_q     <= active_d;
      tok0_q       <= tok0_d;
      rel_q        <= rel_d;
      busy_total_q <= busy_total_d;
      done_q       <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    grant_q  <= grant_d;
    status_q <= status_d;
    map_q    <= map_d;
    count_q  <= count_d;
  end

  assign busy         = active_q;
  assign done_o       = done_q;
  assign grant_map_o  = grant_q;
  assign status_o     = status_q;
  assign busy_map_o   = map_q;
  assign busy_count_o = count_q;

  a_done_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result shown while a transaction is still active");

  a_fail_no_grant : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o) |-> (grant_map_o == '0))
    else $error("failed allocation reports granted units");

  a_count_match : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (busy_count_o == CNT_W'($countones(busy_map_o))))
    else $error("busy count does not match busy map");

  a_release_no_grant : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rel_q) |-> (grant_map_o == '0 && !status_o))
    else $error("release transaction reports a grant or failure");

endmodule

### hw/rtl/uba_cell.sv
// ----------------------------------------------------------------------------
// Allocator cell
// Holds the busy bit of one unit. A token from the lower neighbor may take
// this unit for an allocation and carries the running busy count onward.
// ----------------------------------------------------------------------------
module uba_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  uba_pkg::cell_ctrl_t ctrl_i,
  input  logic                release_i,
  input  logic                present_i,
  input  uba_pkg::token_t     tok_i,
  output uba_pkg::token_t     tok_o,
  output logic                busy_o,
  output logic                grant_o
);
  import uba_pkg::*;

  logic   busy_q, busy_d;
  logic   grant_q, grant_d;
  token_t tok_q, tok_d;
  logic   take;

  assign take = tok_i.vld & tok_i.alloc & present_i & ~busy_q & (tok_i.left != '0);

  always_comb begin
    busy_d  = busy_q;
    grant_d = grant_q;
    if (ctrl_i.start) begin
      grant_d = 1'b0;
      if (ctrl_i.rel && release_i) begin
        busy_d = 1'b0;
      end
    end else if (ctrl_i.commit) begin
      busy_d = busy_q | grant_q;
    end else if (take) begin
      grant_d = 1'b1;
    end
  end

  always_comb begin
    tok_d       = tok_i;
    tok_d.left  = tok_i.left - CNT_W'(take);
    tok_d.cnt   = tok_i.cnt + CNT_W'(busy_q | take);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      grant_q <= 1'b0;
      tok_q   <= '0;
    end else begin
      busy_q  <= busy_d;
      grant_q <= grant_d;
      tok_q   <= tok_d;
    end
  end

  assign tok_o   = tok_q;
  assign busy_o  = busy_q;
  assign grant_o = grant_q;

endmodule

### tb/sv/uba_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Unit bitmap allocator checker
// Watches the APB port and both transaction channels of the allocator. It
// keeps its own copy of total_units and of the busy map, predicts the result
// of every accepted transaction and compares each result with the oldest
// prediction. Register reads are checked against the tracked total_units.
// ----------------------------------------------------------------------------
module uba_checker #(
  parameter int unsigned MAX_UNITS = uba_pkg::MAX_UNITS_DF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [uba_pkg::ADDR_W-1:0] paddr,
  input  logic [uba_pkg::DATA_W-1:0] pwdata,
  input  logic [uba_pkg::DATA_W-1:0] prdata,
  input  logic                       pready,
  input  logic                       start,
  input  logic                       busy,
  input  logic                       cmd_i,
  input  logic [uba_pkg::CNT_W-1:0]  request_count_i,
  input  logic [uba_pkg::MAP_W-1:0]  release_map_i,
  input  logic                       done_i,
  input  logic [uba_pkg::MAP_W-1:0]  grant_map_i,
  input  logic                       status_i,
  input  logic [uba_pkg::MAP_W-1:0]  busy_map_i,
  input  logic [uba_pkg::CNT_W-1:0]  busy_count_i,
  output int                         fail_count_o,
  output int                         pending_o
);
  import uba_pkg::*;

  typedef struct packed {
    logic [MAP_W-1:0] grant_map;
    logic             status;
    logic [MAP_W-1:0] busy_map;
    logic [CNT_W-1:0] busy_count;
  } unit_result_t;

  localparam logic [ADDR_W-1:0] TOTAL_ADDR = {REG_TOTAL_UNITS, 2'b00};

  unit_result_t     outcomes_q[$];
  logic [CNT_W-1:0] total_units;
  logic [MAP_W-1:0] busy_units;
  int               failures;

  function automatic logic [CNT_W-1:0] ones_in(logic [MAP_W-1:0] v);
    logic [CNT_W-1:0] n;
    n = '0;
    for (int i = 0; i < MAP_W; i++) n += CNT_W'(v[i]);
    return n;
  endfunction

  function automatic logic [MAP_W-1:0] present_units(logic [CNT_W-1:0] total);
    int unsigned t;
    t = (total > MAX_UNITS) ? MAX_UNITS : total;
    if (t >= MAP_W) return '1;
    return (MAP_W'(1) << t) - MAP_W'(1);
  endfunction

  function automatic unit_result_t allocate_or_release(logic cmd, logic [CNT_W-1:0] want,
                                                       logic [MAP_W-1:0] rel);
    unit_result_t     r;
    logic [MAP_W-1:0] avail;
    logic [CNT_W-1:0] left;
    r = '0;
    if (cmd == CMD_ALLOC) begin
      avail = present_units(total_units) & ~busy_units;
      if (ones_in(avail) < want) begin
        r.status = 1'b1;
      end else begin
        left = want;
        for (int i = 0; i < MAP_W; i++) begin
          if (left != '0 && avail[i]) begin
            r.grant_map[i] = 1'b1;
            left--;
          end
        end
        busy_units |= r.grant_map;
      end
    end else begin
      busy_units &= ~rel;
    end
    r.busy_map = busy_units;
    r.busy_count = ones_in(busy_units);
    return r;
  endfunction

  task automatic report(input string msg);
    failures++;
    if (failures <= 10) $display("%0t ns: %s", $time, msg);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    unit_result_t expected;
    if (!rst_ni) begin
      outcomes_q.delete();
      total_units = CNT_W'(TOTAL_RST);
      busy_units = '0;
      failures = 0;
    end else begin
      if (done_i === 1'b1) begin
        if (outcomes_q.size() == 0) begin
          report($sformatf("result with no transaction pending: grant %h busy %h",
                           grant_map_i, busy_map_i));
        end else begin
          expected = outcomes_q.pop_front();
          if (grant_map_i !== expected.grant_map || status_i !== expected.status ||
              busy_map_i !== expected.busy_map || busy_count_i !== expected.busy_count) begin
            report($sformatf({"result mismatch (expected/actual): grant %h/%h status %b/%b",
                              " busy %h/%h count %0d/%0d"},
                             expected.grant_map, grant_map_i, expected.status, status_i,
                             expected.busy_map, busy_map_i, expected.busy_count,
                             busy_count_i));
          end
        end
      end
      if (psel && penable && pready && paddr == TOTAL_ADDR) begin
        if (pwrite) begin
          total_units = pwdata[CNT_W-1:0];
        end else if (prdata !== DATA_W'(total_units)) begin
          report($sformatf("total_units read mismatch (expected/actual): %h/%h",
                           DATA_W'(total_units), prdata));
        end
      end
      if (start === 1'b1 && busy === 1'b0) begin
        outcomes_q = {outcomes_q,
                      allocate_or_release(cmd_i, request_count_i, release_map_i)};
      end
    end
    pending_o = outcomes_q.size();
    fail_count_o = failures;
  end

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Unit bitmap allocator testbench
// Drives allocate and release transactions and total_units writes into the
// allocator: a directed sequence over the corner cases, then random traffic
// in three phases with different sender idling. A checker beside the block
// predicts and compares every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
  import uba_pkg::*;

  localparam int unsigned LATENCY     = MAX_UNITS_DF + 2;
  localparam int          CYCLE_LIMIT = 800_000;

  logic              clk_i           = 1'b0;
  logic              rst_ni          = 1'b0;
  logic              psel            = 1'b0;
  logic              penable         = 1'b0;
  logic              pwrite          = 1'b0;
  logic [ADDR_W-1:0] paddr           = '0;
  logic [DATA_W-1:0] pwdata          = '0;
  logic              start           = 1'b0;
  logic              cmd_i           = CMD_ALLOC;
  logic [CNT_W-1:0]  request_count_i = '0;
  logic [MAP_W-1:0]  release_map_i   = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              busy;
  logic              done_o;
  logic [MAP_W-1:0]  grant_map_o;
  logic              status_o;
  logic [MAP_W-1:0]  busy_map_o;
  logic [CNT_W-1:0]  busy_count_o;
  int                fail_count;
  int                pending_count;
  int                cycles = 0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  unit_bitmap_allocator_top DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .start           (start),
    .busy            (busy),
    .cmd_i           (cmd_i),
    .request_count_i (request_count_i),
    .release_map_i   (release_map_i),
    .done_o          (done_o),
    .grant_map_o     (grant_map_o),
    .status_o        (status_o),
    .busy_map_o      (busy_map_o),
    .busy_count_o    (busy_count_o)
  );

  uba_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .start           (start),
    .busy            (busy),
    .cmd_i           (cmd_i),
    .request_count_i (request_count_i),
    .release_map_i   (release_map_i),
    .done_i          (done_o),
    .grant_map_i     (grant_map_o),
    .status_i        (status_o),
    .busy_map_i      (busy_map_o),
    .busy_count_i    (busy_count_o),
    .fail_count_o    (fail_count),
    .pending_o       (pending_count)
  );

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic apb_access(input logic write, input logic [CNT_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= {REG_TOTAL_UNITS, 2'b00};
    pwdata  <= DATA_W'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic issue(input logic cmd, input logic [CNT_W-1:0] cnt,
                       input logic [MAP_W-1:0] map);
    start           <= 1'b1;
    cmd_i           <= cmd;
    request_count_i <= cnt;
    release_map_i   <= map;
    do @(posedge clk_i); while (busy !== 1'b0);
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(negedge clk_i); while (pending_count != 0 || busy !== 1'b0);
    @(posedge clk_i);
  endtask

  task automatic pause_sender(input int unsigned pct);
    if ($urandom_range(99) < pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 100)) @(posedge clk_i);
    end
  endtask

  function automatic logic [CNT_W-1:0] random_total();
    case ($urandom_range(9))
      0:       return '0;
      1:       return CNT_W'(1);
      2:       return CNT_W'(64);
      3:       return CNT_W'($urandom_range(65, 127));
      default: return CNT_W'($urandom_range(1, 64));
    endcase
  endfunction

  task automatic random_item();
    logic [CNT_W-1:0] cnt;
    logic [MAP_W-1:0] map;
    cnt = CNT_W'($urandom);
    map = {$urandom, $urandom};
    if ($urandom_range(99) < 55) begin
      case ($urandom_range(9))
        0:       cnt = CNT_W'($urandom_range(65, 127));
        1, 2:    cnt = CNT_W'($urandom_range(0, 64));
        default: cnt = CNT_W'($urandom_range(0, 8));
      endcase
      issue(CMD_ALLOC, cnt, map);
    end else begin
      case ($urandom_range(9))
        0:       map = '1;
        1, 2:    map = MAP_W'(1) << $urandom_range(63);
        3, 4:    map = map & {$urandom, $urandom};
        default: ;
      endcase
      issue(CMD_RELEASE, cnt, map);
    end
  endtask

  initial begin : stimulus
    int unsigned idle_pct;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    apb_access(1'b0, '0);

    issue(CMD_ALLOC, 7'd0, '0);
    issue(CMD_ALLOC, 7'd1, '0);
    issue(CMD_ALLOC, 7'd64, '0);
    issue(CMD_ALLOC, 7'd63, '0);
    issue(CMD_ALLOC, 7'd1, '0);
    issue(CMD_RELEASE, 7'd0, '1);
    issue(CMD_ALLOC, 7'd127, '0);
    issue(CMD_ALLOC, 7'd64, '0);
    issue(CMD_RELEASE, 7'd0, 64'h8000_0000_0000_0001);
    issue(CMD_ALLOC, 7'd2, '0);
    issue(CMD_RELEASE, 7'd0, 64'h5555_5555_5555_5555);
    issue(CMD_RELEASE, 7'd0, 64'hAAAA_AAAA_AAAA_AAAA);
    issue(CMD_ALLOC, 7'd20, '0);
    drain();
    apb_access(1'b1, 7'd10);
    apb_access(1'b0, '0);
    issue(CMD_ALLOC, 7'd1, '0);
    issue(CMD_RELEASE, 7'd0, 64'h0000_0000_000F_FC00);
    issue(CMD_RELEASE, 7'd0, 64'h3);
    issue(CMD_ALLOC, 7'd2, '0);
    drain();
    apb_access(1'b1, 7'd0);
    issue(CMD_ALLOC, 7'd1, '0);
    issue(CMD_ALLOC, 7'd0, '0);
    drain();
    apb_access(1'b1, 7'd127);
    apb_access(1'b0, '0);
    issue(CMD_ALLOC, 7'd64, '0);
    issue(CMD_RELEASE, 7'd0, '1);
    issue(CMD_ALLOC, 7'd64, '0);
    drain();
    apb_access(1'b1, 7'd1);
    issue(CMD_RELEASE, 7'd0, '1);
    issue(CMD_ALLOC, 7'd1, '0);
    issue(CMD_ALLOC, 7'd1, '0);
    drain();

    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 10 : (phase == 1) ? 45 : 0;
      for (int n = 0; n < 200; n++) begin
        if (n % 50 == 0) begin
          drain();
          apb_access(1'b1, random_total());
          if ($urandom_range(1) == 1) apb_access(1'b0, '0);
        end
        random_item();
        pause_sender(idle_pct);
      end
    end

    drain();
    repeat (LATENCY) @(posedge clk_i);
    if (fail_count == 0 && pending_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
